[design/nvbs_pkg.sv]
// Shared types, step codes and the control-word program of the nearest-value search core.
// Depends on nothing; the interface and core files refer to it by scoped names.
`default_nettype none

package nvbs_pkg;

  localparam int TIME_W  = 63;
  localparam int EIDX_W  = 10;
  localparam int COUNT_W = 11;
  localparam int OIDX_W  = 10;

  typedef logic [2:0] pc_t;
  typedef logic [2:0] op_t;
  typedef logic [1:0] asel_t;
  typedef logic [1:0] cond_t;

  // Program step addresses.
  localparam pc_t P_IDLE  = 3'd0;
  localparam pc_t P_FIRST = 3'd1;
  localparam pc_t P_LAST  = 3'd2;
  localparam pc_t P_MID   = 3'd3;
  localparam pc_t P_PROBE = 3'd4;
  localparam pc_t P_NBR   = 3'd5;
  localparam pc_t P_PICK  = 3'd6;
  localparam pc_t P_EMIT  = 3'd7;

  // Datapath operations.
  localparam op_t OP_IDLE  = 3'd0;
  localparam op_t OP_FIRST = 3'd1;
  localparam op_t OP_LAST  = 3'd2;
  localparam op_t OP_MID   = 3'd3;
  localparam op_t OP_PROBE = 3'd4;
  localparam op_t OP_NBR   = 3'd5;
  localparam op_t OP_PICK  = 3'd6;
  localparam op_t OP_EMIT  = 3'd7;

  // Table read address sources.
  localparam asel_t ASEL_ZERO = 2'd0;
  localparam asel_t ASEL_LAST = 2'd1;
  localparam asel_t ASEL_MID  = 2'd2;
  localparam asel_t ASEL_NBR  = 2'd3;

  // Sequencing: always jump, jump on hit, jump on miss, or hold until hit.
  localparam cond_t C_JUMP = 2'd0;
  localparam cond_t C_HIT  = 2'd1;
  localparam cond_t C_MISS = 2'd2;
  localparam cond_t C_WAIT = 2'd3;

  typedef struct packed {
    asel_t asel;
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    unique case (pc)
      P_IDLE:  w = '{asel: ASEL_ZERO, op: OP_IDLE,  cond: C_WAIT, target: P_FIRST};
      P_FIRST: w = '{asel: ASEL_LAST, op: OP_FIRST, cond: C_HIT,  target: P_EMIT};
      P_LAST:  w = '{asel: ASEL_ZERO, op: OP_LAST,  cond: C_HIT,  target: P_EMIT};
      P_MID:   w = '{asel: ASEL_MID,  op: OP_MID,   cond: C_HIT,  target: P_EMIT};
      P_PROBE: w = '{asel: ASEL_NBR,  op: OP_PROBE, cond: C_HIT,  target: P_EMIT};
      P_NBR:   w = '{asel: ASEL_ZERO, op: OP_NBR,   cond: C_MISS, target: P_MID};
      P_PICK:  w = '{asel: ASEL_ZERO, op: OP_PICK,  cond: C_JUMP, target: P_EMIT};
      P_EMIT:  w = '{asel: ASEL_ZERO, op: OP_EMIT,  cond: C_WAIT, target: P_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[design/nvbs_if.sv]
// Valid/ready channel interfaces for the request and response sides of the search core.
// Field widths come from nvbs_pkg.
`default_nettype none

interface nvbs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [nvbs_pkg::EIDX_W-1:0] entry_index;
  logic [nvbs_pkg::TIME_W-1:0] entry_time;
  logic [nvbs_pkg::TIME_W-1:0] query_time;

  modport source (output valid, kind, entry_index, entry_time, query_time, input ready);
  modport sink   (input valid, kind, entry_index, entry_time, query_time, output ready);
endinterface

interface nvbs_out_if;
  logic                        valid;
  logic                        ready;
  logic [nvbs_pkg::OIDX_W-1:0] closest_index;
  logic                        status;

  modport source (output valid, closest_index, status, input ready);
  modport sink   (input valid, closest_index, status, output ready);
endinterface

`default_nettype wire

[design/nvbs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the timestamp table.
`default_nettype none

module nvbs_ram #(
  parameter int WIDTH = 63,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[design/nearest_value_binary_search_core.sv]
// Nearest-value search core. A query ends early if the table is empty, the target is at or
// below the first entry, or at or above the last entry; else it probes midpoints until an
// exact hit at probe k, a bracketing neighbor check or a closed window, with k up to about
// log2(TABLE_DEPTH) + 1; each probe and neighbor check waits on the registered table read.
// One item is in work at a time. Reset (rst, synchronous) clears the sequencer, the entry
// count and the response valid; table contents are undefined until written.
`default_nettype none

module nearest_value_binary_search_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [nvbs_pkg::COUNT_W-1:0]  cfg_wr_data,
  nvbs_in_if.sink                            req,
  nvbs_out_if.source                         rsp
);

  // IW addresses the table; CW also holds the count itself.
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = IW + 1;

  // Sequencer state and the control word of the current step.
  nvbs_pkg::pc_t    pc;
  nvbs_pkg::pc_t    pc_next;
  nvbs_pkg::ucode_t uc;
  logic             hit;

  // Configuration: the entry count, saturated to the table depth when written.
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_sat;

  // Query working registers.
  logic [nvbs_pkg::TIME_W-1:0] target_q;
  logic                        empty_q;
  logic [CW-1:0]               lo;
  logic [CW-1:0]               hi;
  logic [IW-1:0]               mid;
  logic [nvbs_pkg::TIME_W-1:0] vmid;
  logic                        go_left;
  logic [nvbs_pkg::TIME_W-1:0] diff_lo;
  logic [nvbs_pkg::TIME_W-1:0] diff_hi;
  logic [IW-1:0]               pick_lo;
  logic [IW-1:0]               res;
  logic                        res_status;

  // Table access.
  logic                        wr_en;
  logic [IW-1:0]               rd_addr;
  logic [nvbs_pkg::TIME_W-1:0] rd;

  // Derived datapath values.
  logic                        req_xfer;
  logic [CW:0]                 mid_sum;
  logic [IW-1:0]               mid_calc;
  logic [CW-1:0]               mid_p1;
  logic [IW-1:0]               mid_m1;
  logic [CW-1:0]               last_cnt;
  logic [IW-1:0]               last_idx;
  logic                        go_left_now;
  logic                        nb_ok;
  logic                        between;
  logic [IW+nvbs_pkg::OIDX_W-1:0] res_ext;

  assign uc = nvbs_pkg::ucode_rom(pc);

  // Input is taken only while the sequencer sits in its idle step. A load is written
  // straight into the table; a query starts the program.
  assign req.ready = (uc.op == nvbs_pkg::OP_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign wr_en     = req_xfer && !req.kind && (32'(req.entry_index) < TABLE_DEPTH);

  always_comb begin
    if (32'(cfg_wr_data) > TABLE_DEPTH) begin
      cnt_sat = CW'(TABLE_DEPTH);
    end else begin
      cnt_sat = CW'(cfg_wr_data);
    end
  end

  // Midpoint of the current window; it always lies below hi, so it fits the index width.
  assign mid_sum     = {1'b0, lo} + {1'b0, hi};
  assign mid_calc    = mid_sum[IW:1];
  assign mid_p1      = {1'b0, mid} + CW'(1);
  assign mid_m1      = mid - IW'(1);
  assign last_cnt    = cnt - CW'(1);
  assign last_idx    = last_cnt[IW-1:0];
  assign go_left_now = target_q < rd;

  // Neighbor check: the neighbor must exist inside the table, and the target must lie
  // strictly between it and the probed midpoint.
  assign nb_ok   = go_left ? (mid != '0) : (mid_p1 < cnt);
  assign between = go_left ? (target_q > rd) : (target_q < rd);

  always_comb begin
    unique case (uc.asel)
      nvbs_pkg::ASEL_ZERO: rd_addr = '0;
      nvbs_pkg::ASEL_LAST: rd_addr = last_idx;
      nvbs_pkg::ASEL_MID:  rd_addr = mid_calc;
      nvbs_pkg::ASEL_NBR:  rd_addr = go_left_now ? mid_m1 : mid_p1[IW-1:0];
    endcase
  end

  // The branch condition of each step.
  always_comb begin
    unique case (uc.op)
      nvbs_pkg::OP_IDLE:  hit = req_xfer && req.kind;
      nvbs_pkg::OP_FIRST: hit = empty_q || (target_q <= rd);
      nvbs_pkg::OP_LAST:  hit = target_q >= rd;
      nvbs_pkg::OP_MID:   hit = lo >= hi;
      nvbs_pkg::OP_PROBE: hit = rd == target_q;
      nvbs_pkg::OP_NBR:   hit = nb_ok && between;
      nvbs_pkg::OP_PICK:  hit = 1'b1;
      nvbs_pkg::OP_EMIT:  hit = !rsp.valid || rsp.ready;
    endcase
  end

  always_comb begin
    unique case (uc.cond)
      nvbs_pkg::C_JUMP: pc_next = uc.target;
      nvbs_pkg::C_HIT:  pc_next = hit ? uc.target : pc + 3'd1;
      nvbs_pkg::C_MISS: pc_next = hit ? pc + 3'd1 : uc.target;
      nvbs_pkg::C_WAIT: pc_next = hit ? uc.target : pc;
    endcase
  end

  nvbs_ram #(
    .WIDTH (nvbs_pkg::TIME_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IW'(req.entry_index)),
    .wr_data (req.entry_time),
    .rd_addr (rd_addr),
    .rd_data (rd)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= nvbs_pkg::P_IDLE;
      cnt       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_wr_en) begin
        cnt <= cnt_sat;
      end
      if (uc.op == nvbs_pkg::OP_EMIT && hit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Datapath registers, updated by the operation of the current step.
  always_ff @(posedge clk) begin
    unique case (uc.op)
      nvbs_pkg::OP_IDLE: begin
        if (req_xfer) begin
          target_q <= req.query_time;
          empty_q  <= (cnt == '0);
        end
      end
      nvbs_pkg::OP_FIRST: begin
        // An empty table also leaves here, with index 0 and the empty status.
        res        <= '0;
        res_status <= empty_q;
      end
      nvbs_pkg::OP_LAST: begin
        res <= last_idx;
        lo  <= '0;
        hi  <= cnt;
        mid <= '0;
      end
      nvbs_pkg::OP_MID: begin
        // When the window has closed, the last probed midpoint is the answer.
        if (hit) begin
          res <= mid;
        end else begin
          mid <= mid_calc;
        end
      end
      nvbs_pkg::OP_PROBE: begin
        res     <= mid;
        vmid    <= rd;
        go_left <= go_left_now;
      end
      nvbs_pkg::OP_NBR: begin
        // Distances to the lower and upper of the two bracketing entries.
        diff_lo <= target_q - (go_left ? rd : vmid);
        diff_hi <= (go_left ? vmid : rd) - target_q;
        pick_lo <= go_left ? mid_m1 : mid;
        if (go_left) begin
          hi <= {1'b0, mid};
        end else begin
          lo <= mid_p1;
        end
      end
      nvbs_pkg::OP_PICK: begin
        // The upper entry wins ties.
        res <= (diff_lo >= diff_hi) ? pick_lo + IW'(1) : pick_lo;
      end
      nvbs_pkg::OP_EMIT: begin
        if (hit) begin
          rsp.closest_index <= res_ext[nvbs_pkg::OIDX_W-1:0];
          rsp.status        <= res_status;
        end
      end
    endcase
  end

  // The reported index is the found index taken to its low ten bits.
  assign res_ext = {{nvbs_pkg::OIDX_W{1'b0}}, res};

endmodule

`default_nettype wire
